// ===== design/kps_pkg.sv =====
// Shared types and constants for the keyframe pose sampler.
package kps_pkg;

    localparam int MAX_BONES  = 64;
    localparam int MAX_FRAMES = 256;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_LOOP   = 3'd0;
    localparam logic [2:0] CFG_LENGTH = 3'd1;
    localparam logic [2:0] CFG_RATE   = 3'd2;
    localparam logic [2:0] CFG_FRAMES = 3'd3;
    localparam logic [2:0] CFG_BONES  = 3'd4;

    localparam logic [30:0] LEN_THRESH   = 31'd6;
    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [23:0] RATE_DEFAULT = 24'd1966080;
    localparam logic [3:0]  LAST_ELEMENT = 4'd15;

    typedef struct packed {
        logic               operation;
        logic [5:0]         bone;
        logic [7:0]         frame;
        logic [3:0]         element;
        logic signed [31:0] key_value;
        logic signed [31:0] sample_time;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]         out_bone;
        logic [3:0]         out_element;
        logic signed [31:0] blended_value;
        logic               used_identity;
        logic               finished;
        logic               last;
    } out_beat_t;

endpackage

// ===== design/kps_in_if.sv =====
// Request channel: valid/ready with one request beat.
interface kps_in_if import kps_pkg::*; ();
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/kps_out_if.sv =====
// Pose element channel: valid/ready with one element beat.
interface kps_out_if import kps_pkg::*; ();
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/kps_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module kps_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [30:0] den,
    output logic        done,
    output logic [30:0] rem
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [30:0] den_reg, den_next;
    logic [30:0] rem_reg, rem_next;
    logic [31:0] trial;

    assign trial = {rem_reg, num_reg[31]};
    assign done  = busy_reg && (cnt_reg == 6'd0);
    assign rem   = rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                num_next = {num_reg[30:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 31'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = trial[30:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== design/keyframe_pose_sampler.sv =====
// Keyframe pose sampler top level. A load beat writes one key element. A
// sample beat is set up by the time wrap (when looping with a long sequence),
// the position and frame select, and the frame wrap (when looping and no
// identity pose is used); the shared remainder unit does both wraps. Each of
// the 16 elements then goes through key store read, multiply, round and
// hand-off, and the hand-off waits until the sink is ready. The key store is a
// single memory with two read ports; one request is in flight at a time and
// contents are undefined until loaded.
module keyframe_pose_sampler import kps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kps_in_if.sink      req,
    kps_out_if.source   pose,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int DEPTH  = MAX_BONES * MAX_FRAMES * 16;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TDIV = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_SEL  = 4'd3;
    localparam logic [3:0] S_FDIV = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;

    logic        loop_reg;
    logic [30:0] len_reg;
    logic [23:0] rate_reg;
    logic [8:0]  fcnt_reg;
    logic [6:0]  bcnt_reg;

    logic [3:0]  st_reg, st_next;
    logic [5:0]  bone_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] tw_reg;
    logic signed [56:0] pos_reg;
    logic        fin_reg, ident_reg;
    logic [8:0]  f0_reg, f1_reg;
    logic [16:0] alpha_reg;
    logic [3:0]  k_reg;
    logic signed [49:0] p0_reg, p1_reg;
    logic signed [31:0] rd0_reg, rd1_reg;
    logic        ovalid_reg;
    out_beat_t   obeat_reg;

    logic signed [31:0] mem [DEPTH];

    logic        long_seq, div_start, div_done;
    logic [31:0] div_num;
    logic [30:0] div_den, div_rem;
    logic [8:0]  fc;
    logic        bone_bad;
    logic [22:0] ip;
    logic [ADDR_W-1:0] rd_addr0, rd_addr1, wr_addr;
    logic        wr_en;
    logic signed [49:0] acc;
    logic signed [33:0] v;
    logic signed [31:0] v_sat;
    logic [8:0]  f0_inc;

    kps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .rem   (div_rem)
    );

    assign long_seq = len_reg > LEN_THRESH;
    assign fc       = (int'(fcnt_reg) > MAX_FRAMES) ? 9'(MAX_FRAMES) : fcnt_reg;
    assign bone_bad = int'(bone_reg) >= ((int'(bcnt_reg) > MAX_BONES) ? MAX_BONES
                                                                      : int'(bcnt_reg));
    assign ip       = pos_reg[54:32];
    assign f0_inc   = div_rem[8:0] + 9'd1;

    assign req.ready  = (st_reg == S_IDLE);
    assign pose.valid = ovalid_reg;
    assign pose.data  = obeat_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = req.data.sample_time[31] ? 32'(-req.data.sample_time)
                                             : req.data.sample_time;
        div_den   = len_reg;
        if (st_reg == S_IDLE)
        begin
            div_start = req.valid && (req.data.operation == OP_SAMPLE)
                        && long_seq && loop_reg;
        end
        else if (st_reg == S_SEL)
        begin
            div_num   = {9'd0, ip};
            div_den   = {22'd0, fc};
            div_start = loop_reg && !(bone_bad || (fc == 9'd0) || pos_reg[56]);
        end
    end

    assign wr_en   = (st_reg == S_IDLE) && req.valid && (req.data.operation == OP_LOAD)
                     && (int'(req.data.bone) < MAX_BONES)
                     && (int'(req.data.frame) < MAX_FRAMES);
    assign wr_addr = ADDR_W'((int'(req.data.bone) * MAX_FRAMES + int'(req.data.frame)) * 16
                             + int'(req.data.element));
    assign rd_addr0 = ADDR_W'((int'(bone_reg) * MAX_FRAMES + int'(f0_reg)) * 16 + int'(k_reg));
    assign rd_addr1 = ADDR_W'((int'(bone_reg) * MAX_FRAMES + int'(f1_reg)) * 16 + int'(k_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.data.key_value;
        end
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
    end

    assign acc   = p0_reg + p1_reg + 50'sd32768;
    assign v     = 34'(acc >>> 16);
    assign v_sat = (v > 34'sd2147483647) ? 32'sh7FFF_FFFF
                 : (v < -34'sd2147483648) ? 32'sh8000_0000 : v[31:0];

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (req.valid && (req.data.operation == OP_SAMPLE))
                begin
                    st_next = (long_seq && loop_reg) ? S_TDIV : S_POS;
                end
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    st_next = S_POS;
                end
            end
            S_POS:  st_next = S_SEL;
            S_SEL:  st_next = div_start ? S_FDIV : S_READ;
            S_FDIV:
            begin
                if (div_done)
                begin
                    st_next = S_READ;
                end
            end
            S_READ: st_next = S_MUL;
            S_MUL:  st_next = S_SUM;
            S_SUM:  st_next = S_OUT;
            S_OUT:
            begin
                if (pose.ready)
                begin
                    st_next = (k_reg == LAST_ELEMENT) ? S_IDLE : S_READ;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg   <= 1'b0;
            len_reg    <= '0;
            rate_reg   <= RATE_DEFAULT;
            fcnt_reg   <= '0;
            bcnt_reg   <= '0;
            st_reg     <= S_IDLE;
            ovalid_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOP:   loop_reg <= cfg_data[0];
                    CFG_LENGTH: len_reg  <= cfg_data;
                    CFG_RATE:   rate_reg <= cfg_data[23:0];
                    CFG_FRAMES: fcnt_reg <= cfg_data[8:0];
                    CFG_BONES:  bcnt_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            st_reg <= st_next;
            if (st_reg == S_SUM)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (st_reg == S_OUT && pose.ready)
            begin
                ovalid_reg <= 1'b0;
                k_reg      <= k_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                bone_reg <= req.data.bone;
                t_reg    <= req.data.sample_time;
                fin_reg  <= !loop_reg && long_seq
                            && (33'(req.data.sample_time) >=
                                $signed({2'b00, len_reg}) - 33'sd6);
                if (long_seq && !loop_reg)
                begin
                    if (req.data.sample_time[31])
                    begin
                        tw_reg <= '0;
                    end
                    else if (req.data.sample_time > $signed({1'b0, len_reg}))
                    begin
                        tw_reg <= $signed({1'b0, len_reg});
                    end
                    else
                    begin
                        tw_reg <= req.data.sample_time;
                    end
                end
                else
                begin
                    tw_reg <= req.data.sample_time;
                end
            end
            S_TDIV:
            begin
                if (t_reg[31] && div_rem != 31'd0)
                begin
                    tw_reg <= $signed({1'b0, 31'(len_reg - div_rem)});
                end
                else
                begin
                    tw_reg <= $signed({1'b0, div_rem});
                end
            end
            S_POS:
            begin
                pos_reg <= 57'(tw_reg) * 57'($signed({1'b0, rate_reg}));
            end
            S_SEL:
            begin
                ident_reg <= bone_bad || (fc == 9'd0) || pos_reg[56];
                if (!loop_reg)
                begin
                    if ({1'b0, ip} >= 24'(fc - 9'd1))
                    begin
                        f0_reg    <= fc - 9'd1;
                        f1_reg    <= fc - 9'd1;
                        alpha_reg <= '0;
                    end
                    else
                    begin
                        f0_reg    <= ip[8:0];
                        f1_reg    <= ip[8:0] + 9'd1;
                        alpha_reg <= {1'b0, pos_reg[31:16]};
                    end
                end
                else
                begin
                    alpha_reg <= {1'b0, pos_reg[31:16]};
                end
            end
            S_FDIV:
            begin
                f0_reg <= div_rem[8:0];
                f1_reg <= (f0_inc == fc) ? 9'd0 : f0_inc;
            end
            S_MUL:
            begin
                p0_reg <= 50'(rd0_reg)
                          * 50'($signed({1'b0, 17'(ONE_Q16[16:0] - alpha_reg)}));
                p1_reg <= 50'(rd1_reg) * 50'($signed({1'b0, alpha_reg}));
            end
            S_SUM:
            begin
                obeat_reg.out_bone      <= bone_reg;
                obeat_reg.out_element   <= k_reg;
                obeat_reg.used_identity <= ident_reg;
                obeat_reg.finished      <= fin_reg;
                obeat_reg.last          <= (k_reg == LAST_ELEMENT);
                if (ident_reg)
                begin
                    obeat_reg.blended_value <= (k_reg == 4'd0 || k_reg == 4'd5 ||
                                                k_reg == 4'd10 || k_reg == 4'd15)
                                               ? ONE_Q16 : 32'sd0;
                end
                else
                begin
                    obeat_reg.blended_value <= v_sat;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) pose.valid |-> st_reg == S_OUT)
        else $error("pose beat outside hand-off");
    assert property (@(posedge clk) disable iff (!rst_n) req.ready |-> !pose.valid)
        else $error("request taken while pose pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid && pose.data.last |-> pose.data.out_element == LAST_ELEMENT)
        else $error("last mark on wrong element");
    assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid && pose.ready && !pose.data.last |=> !req.ready)
        else $error("pose ended early");

endmodule
